// ===== hw/rtl/rgbmpp_pkg.sv =====
// Shared constants and types for the masked pixel packer.
package rgbmpp_pkg;

    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int MASK_W     = 32;
    localparam int BPP_W      = 6;
    localparam int DIM_W      = 13;
    localparam int STRIDE_W   = 15;
    localparam int OFF_W      = 26;
    localparam int PIX_W      = 32;
    localparam int BC_W       = 3;
    localparam int SH_W       = 5;
    localparam int Q_W        = 25;
    localparam int R_W        = 7;
    localparam int PR_W       = CH_W + R_W;
    localparam int CFG_ADDR_W = 3;
    localparam int MAX_PIX_BYTES = 4;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RED_MASK    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GREEN_MASK  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BLUE_MASK   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BPP         = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_FIRST   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HGT   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_LINE_STRIDE = 3'd7;

    // channel slots
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam logic [MASK_W-1:0]   RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [MASK_W-1:0]   GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [MASK_W-1:0]   BLUE_MASK_RST  = 32'h0000_00FF;
    localparam logic [BPP_W-1:0]    BPP_RST        = 6'd32;
    localparam logic                LOW_FIRST_RST  = 1'b1;
    localparam logic [DIM_W-1:0]    FRAME_W_RST    = 13'd640;
    localparam logic [DIM_W-1:0]    FRAME_H_RST    = 13'd480;
    localparam logic [STRIDE_W-1:0] STRIDE_RST     = 15'd2560;

    // per-channel scale: value*(2^w-1)/255 = value*q + (value*r)/255
    typedef struct packed {
        logic [SH_W-1:0] shift;
        logic [Q_W-1:0]  q;
        logic [R_W-1:0]  r;
    } chan_t;

    typedef struct packed {
        logic [BC_W-1:0]     byte_cnt;
        logic [DIM_W-1:0]    frame_width;
        logic [DIM_W-1:0]    frame_height;
        logic [STRIDE_W-1:0] line_stride;
    } front_cfg_t;

    typedef struct packed {
        chan_t [NUM_CH-1:0] chan;
        logic               low_first;
    } back_cfg_t;

    typedef struct packed {
        logic [OFF_W-1:0] byte_offset;
        logic [BC_W-1:0]  byte_cnt;
        logic             frame_end;
    } meta_t;

    typedef struct packed {
        logic [NUM_CH-1:0][CH_W-1:0] color;
        meta_t                       meta;
    } item_t;

endpackage

// ===== hw/rtl/rgbmpp_cfg.sv =====
// Configuration registers and registered channel-mask decode.
module rgbmpp_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [rgbmpp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [rgbmpp_pkg::MASK_W-1:0]       cfg_wdata,
    output rgbmpp_pkg::front_cfg_t              front_cfg,
    output rgbmpp_pkg::back_cfg_t               back_cfg
);
    import rgbmpp_pkg::*;

    function automatic logic [MASK_W-1:0] mask_low(input logic [MASK_W-1:0] m);
        return m & (~m + MASK_W'(1));
    endfunction

    // lowest run of ones: adding the low bit clears the run and carries past it
    function automatic logic [MASK_W-1:0] mask_run(input logic [MASK_W-1:0] m);
        return m & ~(m + mask_low(m));
    endfunction

    function automatic chan_t chan_decode(input logic [MASK_W-1:0] low,
                                          input logic [MASK_W-1:0] run);
        chan_t          d;
        logic [SH_W-1:0] sh;
        logic [5:0]     w;
        logic [2:0]     j;
        logic [2:0]     rr;
        logic [Q_W-1:0] pat;
        sh  = '0;
        w   = '0;
        pat = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (low[i]) sh = sh | SH_W'(i);
            w = w + 6'(run[i]);
        end
        // 2^w-1 = 255 * (2^rr * sum 256^i, i<j) + (2^rr - 1), w = 8j + rr
        j  = w[5:3];
        rr = w[2:0];
        for (int b = 0; b < MAX_PIX_BYTES; b++) begin
            if (3'(b) < j) pat[8*b] = 1'b1;
        end
        d.shift = sh;
        d.q     = pat << rr;
        d.r     = R_W'((8'd1 << rr) - 8'd1);
        return d;
    endfunction

    logic [MASK_W-1:0]   low_reg [NUM_CH];
    logic [MASK_W-1:0]   run_reg [NUM_CH];
    chan_t               dec_reg [NUM_CH];
    logic [BPP_W-1:0]    bpp_reg;
    logic                lsb_reg;
    logic [DIM_W-1:0]    fw_reg;
    logic [DIM_W-1:0]    fh_reg;
    logic [STRIDE_W-1:0] stride_reg;

    logic [MASK_W-1:0]   wr_low;
    logic [MASK_W-1:0]   wr_run;
    logic [3:0]          cnt_raw;

    assign wr_low = mask_low(cfg_wdata);
    assign wr_run = mask_run(cfg_wdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg[CH_RED]   <= mask_low(RED_MASK_RST);
            run_reg[CH_RED]   <= mask_run(RED_MASK_RST);
            low_reg[CH_GREEN] <= mask_low(GREEN_MASK_RST);
            run_reg[CH_GREEN] <= mask_run(GREEN_MASK_RST);
            low_reg[CH_BLUE]  <= mask_low(BLUE_MASK_RST);
            run_reg[CH_BLUE]  <= mask_run(BLUE_MASK_RST);
            bpp_reg           <= BPP_RST;
            lsb_reg           <= LOW_FIRST_RST;
            fw_reg            <= FRAME_W_RST;
            fh_reg            <= FRAME_H_RST;
            stride_reg        <= STRIDE_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_RED_MASK: begin
                    low_reg[CH_RED] <= wr_low;
                    run_reg[CH_RED] <= wr_run;
                end
                REG_GREEN_MASK: begin
                    low_reg[CH_GREEN] <= wr_low;
                    run_reg[CH_GREEN] <= wr_run;
                end
                REG_BLUE_MASK: begin
                    low_reg[CH_BLUE] <= wr_low;
                    run_reg[CH_BLUE] <= wr_run;
                end
                REG_BPP:         bpp_reg    <= cfg_wdata[BPP_W-1:0];
                REG_LOW_FIRST:   lsb_reg    <= cfg_wdata[0];
                REG_FRAME_WIDTH: fw_reg     <= cfg_wdata[DIM_W-1:0];
                REG_FRAME_HGT:   fh_reg     <= cfg_wdata[DIM_W-1:0];
                REG_LINE_STRIDE: stride_reg <= cfg_wdata[STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // decode is registered from the stored masks, one register behind them
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_reg[CH_RED]   <= chan_decode(mask_low(RED_MASK_RST), mask_run(RED_MASK_RST));
            dec_reg[CH_GREEN] <= chan_decode(mask_low(GREEN_MASK_RST),
                                             mask_run(GREEN_MASK_RST));
            dec_reg[CH_BLUE]  <= chan_decode(mask_low(BLUE_MASK_RST), mask_run(BLUE_MASK_RST));
        end else begin
            for (int c = 0; c < NUM_CH; c++) begin
                dec_reg[c] <= chan_decode(low_reg[c], run_reg[c]);
            end
        end
    end

    assign cnt_raw = 4'((7'(bpp_reg) + 7'd7) >> 3);

    always_comb begin
        if (cnt_raw == 4'd0) begin
            front_cfg.byte_cnt = BC_W'(1);
        end else if (cnt_raw > 4'(MAX_PIX_BYTES)) begin
            front_cfg.byte_cnt = BC_W'(MAX_PIX_BYTES);
        end else begin
            front_cfg.byte_cnt = cnt_raw[BC_W-1:0];
        end
        front_cfg.frame_width  = fw_reg;
        front_cfg.frame_height = fh_reg;
        front_cfg.line_stride  = stride_reg;
        for (int c = 0; c < NUM_CH; c++) begin
            back_cfg.chan[c] = dec_reg[c];
        end
        back_cfg.low_first = lsb_reg;
    end

endmodule

// ===== hw/rtl/rgbmpp_front.sv =====
// Input side: raster position tracking, byte offset and end-of-frame tagging.
module rgbmpp_front #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rgbmpp_pkg::CH_W-1:0]   s_red,
    input  logic [rgbmpp_pkg::CH_W-1:0]   s_green,
    input  logic [rgbmpp_pkg::CH_W-1:0]   s_blue,
    input  rgbmpp_pkg::front_cfg_t        front_cfg,
    input  logic                          q_full,
    output logic                          q_push,
    output rgbmpp_pkg::item_t             q_item
);
    import rgbmpp_pkg::*;

    localparam int COL_W = $clog2(MAX_DIMENSION);
    localparam int LIM_W = $clog2(MAX_DIMENSION + 1);

    function automatic logic [LIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0) return LIM_W'(1);
        if (32'(v) > 32'(MAX_DIMENSION)) return LIM_W'(MAX_DIMENSION);
        return LIM_W'(v);
    endfunction

    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] row_reg, row_next;
    logic [OFF_W-1:0] row_base_reg, row_base_next;

    logic [LIM_W-1:0] w_lim, h_lim, col_inc, row_inc;
    logic             row_wrap, frame_wrap, accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign w_lim   = clamp_dim(front_cfg.frame_width);
    assign h_lim   = clamp_dim(front_cfg.frame_height);
    assign col_inc = LIM_W'(col_reg) + LIM_W'(1);
    assign row_inc = LIM_W'(row_reg) + LIM_W'(1);

    // a position at or past a shrunken limit wraps just like the last one
    assign row_wrap   = col_inc >= w_lim;
    assign frame_wrap = row_wrap && (row_inc >= h_lim);

    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        if (row_wrap) begin
            col_next = '0;
            if (frame_wrap) begin
                row_next      = '0;
                row_base_next = '0;
            end else begin
                row_next      = COL_W'(row_inc);
                row_base_next = row_base_reg + OFF_W'(front_cfg.line_stride);
            end
        end else begin
            col_next = COL_W'(col_inc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
        end else if (accept) begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            row_base_reg <= row_base_next;
        end
    end

    assign q_push                  = accept;
    assign q_item.color[CH_RED]    = s_red;
    assign q_item.color[CH_GREEN]  = s_green;
    assign q_item.color[CH_BLUE]   = s_blue;
    assign q_item.meta.byte_offset = row_base_reg
                                   + OFF_W'(col_reg) * OFF_W'(front_cfg.byte_cnt);
    assign q_item.meta.byte_cnt    = front_cfg.byte_cnt;
    assign q_item.meta.frame_end   = frame_wrap;

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && frame_wrap |=> col_reg == '0 && row_reg == '0 && row_base_reg == '0)
        else $error("position not cleared after last pixel of frame");

endmodule

// ===== hw/rtl/rgbmpp_queue.sv =====
// Two-entry queue between the input side and the pixel datapath.
module rgbmpp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  rgbmpp_pkg::item_t  push_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output rgbmpp_pkg::item_t  head
);
    import rgbmpp_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   cnt_reg, cnt_next;

    assign full  = cnt_reg == (PTR_W + 1)'(DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + (PTR_W + 1)'(1);
        if (pop && !push) cnt_next = cnt_reg - (PTR_W + 1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("queue read while empty");

endmodule

// ===== hw/rtl/rgbmpp_back.sv =====
// Pixel datapath: channel scaling, mask placement, byte ordering, output register.
module rgbmpp_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_empty,
    input  rgbmpp_pkg::item_t              q_head,
    output logic                           q_pop,
    input  rgbmpp_pkg::back_cfg_t          back_cfg,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rgbmpp_pkg::OFF_W-1:0]   m_byte_offset,
    output logic [rgbmpp_pkg::PIX_W-1:0]   m_pixel_bytes,
    output logic [rgbmpp_pkg::BC_W-1:0]    m_byte_cnt,
    output logic                           m_frame_end
);
    import rgbmpp_pkg::*;

    // exact floor(x/255) for x up to 255*127
    function automatic logic [R_W-1:0] div255(input logic [PR_W-1:0] x);
        logic [PR_W:0] s;
        s = (PR_W + 1)'(x) + (PR_W + 1)'(x >> 8) + (PR_W + 1)'(1);
        return R_W'(s >> 8);
    endfunction

    function automatic logic [PIX_W-1:0] pack_bytes(input logic [PIX_W-1:0] pix,
                                                     input logic [BC_W-1:0]  cnt,
                                                     input logic             lsb);
        logic [PIX_W-1:0] o;
        logic [1:0]       src;
        o = '0;
        for (int k = 0; k < MAX_PIX_BYTES; k++) begin
            if (BC_W'(k) < cnt) begin
                src = lsb ? 2'(k) : 2'(cnt - BC_W'(1) - BC_W'(k));
                o[8*k +: 8] = pix[{src, 3'b000} +: 8];
            end
        end
        return o;
    endfunction

    logic                      b1_v_reg, b2_v_reg, m_valid_reg;
    logic [PIX_W-1:0]          pq_reg [NUM_CH];
    logic [PIX_W-1:0]          pq_next [NUM_CH];
    logic [PR_W-1:0]           pr_reg [NUM_CH];
    logic [PR_W-1:0]           pr_next [NUM_CH];
    meta_t                     b1_meta_reg, b2_meta_reg;
    logic [PIX_W-1:0]          pix_reg, pix_next;
    logic [OFF_W-1:0]          off_reg;
    logic [PIX_W-1:0]          bytes_reg, bytes_next;
    logic [BC_W-1:0]           cnt_reg;
    logic                      fend_reg;

    logic out_free, b2_free, b1_free;

    assign out_free = !m_valid_reg || m_ready;
    assign b2_free  = !b2_v_reg || out_free;
    assign b1_free  = !b1_v_reg || b2_free;
    assign q_pop    = !q_empty && b1_free;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            pq_next[c] = PIX_W'(PIX_W'(q_head.color[c]) * PIX_W'(back_cfg.chan[c].q));
            pr_next[c] = PR_W'(q_head.color[c]) * PR_W'(back_cfg.chan[c].r);
        end
    end

    always_comb begin
        pix_next = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            pix_next = pix_next
                     | ((pq_reg[c] + PIX_W'(div255(pr_reg[c]))) << back_cfg.chan[c].shift);
        end
    end

    assign bytes_next = pack_bytes(pix_reg, b2_meta_reg.byte_cnt, back_cfg.low_first);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_v_reg    <= 1'b0;
            b2_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (b1_free)  b1_v_reg    <= !q_empty;
            if (b2_free)  b2_v_reg    <= b1_v_reg;
            if (out_free) m_valid_reg <= b2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            for (int c = 0; c < NUM_CH; c++) begin
                pq_reg[c] <= pq_next[c];
                pr_reg[c] <= pr_next[c];
            end
            b1_meta_reg <= q_head.meta;
        end
        if (b1_v_reg && b2_free) begin
            pix_reg     <= pix_next;
            b2_meta_reg <= b1_meta_reg;
        end
        if (b2_v_reg && out_free) begin
            off_reg   <= b2_meta_reg.byte_offset;
            bytes_reg <= bytes_next;
            cnt_reg   <= b2_meta_reg.byte_cnt;
            fend_reg  <= b2_meta_reg.frame_end;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_byte_offset = off_reg;
    assign m_pixel_bytes = bytes_reg;
    assign m_byte_cnt    = cnt_reg;
    assign m_frame_end   = fend_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_byte_cnt != '0 && m_byte_cnt <= BC_W'(MAX_PIX_BYTES))
        else $error("byte count out of range");

    a_single_byte_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_cnt == BC_W'(1) |-> m_pixel_bytes[PIX_W-1:8] == '0)
        else $error("bytes beyond count not cleared");

endmodule

// ===== hw/rtl/rgb888_to_masked_pixel_packer.sv =====
// Top level of the RGB888 to masked pixel packer.
//
//  port group   dir  handshake          contents
//  s_*          in   s_valid/s_ready    red, green, blue of one raster-order pixel
//  m_*          out  m_valid/m_ready    byte_offset, pixel_bytes, byte_cnt, frame_end
//  cfg_*        in   cfg_we only        register index and write data, no read-back
//
//  One pixel per clock sustained while m_ready stays high. After its transfer in,
//  a result goes through the channel multiply stage, the shift/merge stage and the
//  output register; an item passes through the queue without extra delay.
//  Synchronous active-low reset clears position counters and all valids and
//  loads the register defaults; mask decode is registered behind the mask registers.
//  A stalled output holds its result; s_ready drops once five pixels are held
//  (three stages plus the two-entry queue).
module rgb888_to_masked_pixel_packer #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rgbmpp_pkg::CH_W-1:0]         s_red,
    input  logic [rgbmpp_pkg::CH_W-1:0]         s_green,
    input  logic [rgbmpp_pkg::CH_W-1:0]         s_blue,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rgbmpp_pkg::OFF_W-1:0]        m_byte_offset,
    output logic [rgbmpp_pkg::PIX_W-1:0]        m_pixel_bytes,
    output logic [rgbmpp_pkg::BC_W-1:0]         m_byte_cnt,
    output logic                                m_frame_end,
    input  logic                                cfg_we,
    input  logic [rgbmpp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [rgbmpp_pkg::MASK_W-1:0]       cfg_wdata
);
    import rgbmpp_pkg::*;

    front_cfg_t front_cfg;
    back_cfg_t  back_cfg;
    item_t      push_item, head_item;
    logic       q_push, q_pop, q_full, q_empty;

    rgbmpp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .front_cfg (front_cfg),
        .back_cfg  (back_cfg)
    );

    rgbmpp_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_red     (s_red),
        .s_green   (s_green),
        .s_blue    (s_blue),
        .front_cfg (front_cfg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    rgbmpp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (head_item)
    );

    rgbmpp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_head        (head_item),
        .q_pop         (q_pop),
        .back_cfg      (back_cfg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_byte_offset (m_byte_offset),
        .m_pixel_bytes (m_pixel_bytes),
        .m_byte_cnt    (m_byte_cnt),
        .m_frame_end   (m_frame_end)
    );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the masked pixel packer: directed and random pixels with a scoreboard.
module tb;
    import rgbmpp_pkg::*;

    localparam int TIMEOUT_CYCLES = 200000;
    localparam int MAX_DIM        = 4096;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [OFF_W-1:0] byte_offset;
        logic [PIX_W-1:0] pixel_bytes;
        logic [BC_W-1:0]  byte_cnt;
        logic             frame_end;
    } packed_pixel_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [CH_W-1:0]       s_red     = '0;
    logic [CH_W-1:0]       s_green   = '0;
    logic [CH_W-1:0]       s_blue    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [OFF_W-1:0]      m_byte_offset;
    logic [PIX_W-1:0]      m_pixel_bytes;
    logic [BC_W-1:0]       m_byte_cnt;
    logic                  m_frame_end;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [MASK_W-1:0]     cfg_wdata = '0;

    rgb888_to_masked_pixel_packer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_byte_offset (m_byte_offset),
        .m_pixel_bytes (m_pixel_bytes),
        .m_byte_cnt    (m_byte_cnt),
        .m_frame_end   (m_frame_end),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // shadow of the format registers and of the raster position
    logic [MASK_W-1:0] fmt_reg [8];
    int unsigned       col_pos   = 0;
    int unsigned       row_pos   = 0;
    logic [OFF_W-1:0]  row_start = '0;

    rgb_t          pixel_queue[$];
    packed_pixel_t expected_pixels[$];
    packed_pixel_t want;

    logic        sent       = 1'b0;
    logic        gaps_on    = 1'b1;
    logic        hold_send  = 1'b0;
    logic        stall_kick = 1'b0;
    int unsigned stall_left = 0;
    int unsigned err_count  = 0;
    int unsigned cycle_count = 0;

    initial begin
        fmt_reg[REG_RED_MASK]    = RED_MASK_RST;
        fmt_reg[REG_GREEN_MASK]  = GREEN_MASK_RST;
        fmt_reg[REG_BLUE_MASK]   = BLUE_MASK_RST;
        fmt_reg[REG_BPP]         = MASK_W'(BPP_RST);
        fmt_reg[REG_LOW_FIRST]   = MASK_W'(LOW_FIRST_RST);
        fmt_reg[REG_FRAME_WIDTH] = MASK_W'(FRAME_W_RST);
        fmt_reg[REG_FRAME_HGT]   = MASK_W'(FRAME_H_RST);
        fmt_reg[REG_LINE_STRIDE] = MASK_W'(STRIDE_RST);
    end

    function automatic logic [PIX_W-1:0] scale_channel(logic [CH_W-1:0] value,
                                                       logic [MASK_W-1:0] mask);
        logic [MASK_W-1:0] m;
        int unsigned       lsb;
        int unsigned       run;
        logic [63:0]       top;
        logic [63:0]       level;
        if (mask == '0)
            return '0;
        m   = mask;
        lsb = 0;
        run = 0;
        while (!m[0]) begin
            m = m >> 1;
            lsb++;
        end
        // only the lowest run of ones counts
        while (run < 32 && m[0]) begin
            m = m >> 1;
            run++;
        end
        top   = (64'd1 << run) - 64'd1;
        level = ({56'd0, value} * top) / 64'd255;
        level = level << lsb;
        return level[PIX_W-1:0];
    endfunction

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    task automatic predict_packed_pixel(input rgb_t px);
        packed_pixel_t    r;
        logic [PIX_W-1:0] word;
        int unsigned      nbytes;
        int unsigned      fw;
        int unsigned      fh;
        int unsigned      src;
        logic [OFF_W-1:0] x_off;
        nbytes = (fmt_reg[REG_BPP][BPP_W-1:0] + 7) / 8;
        if (nbytes == 0)
            nbytes = 1;
        if (nbytes > MAX_PIX_BYTES)
            nbytes = MAX_PIX_BYTES;
        fw   = clamp_dim(fmt_reg[REG_FRAME_WIDTH][DIM_W-1:0]);
        fh   = clamp_dim(fmt_reg[REG_FRAME_HGT][DIM_W-1:0]);
        word = scale_channel(px.red, fmt_reg[REG_RED_MASK])
             | scale_channel(px.green, fmt_reg[REG_GREEN_MASK])
             | scale_channel(px.blue, fmt_reg[REG_BLUE_MASK]);
        r = '0;
        for (int k = 0; k < nbytes; k++) begin
            src = fmt_reg[REG_LOW_FIRST][0] ? k : nbytes - 1 - k;
            r.pixel_bytes[8*k +: 8] = word[8*src +: 8];
        end
        x_off         = OFF_W'(col_pos * nbytes);
        r.byte_offset = row_start + x_off;
        r.byte_cnt    = BC_W'(nbytes);
        // a position past a shrunken frame closes the row or frame at once
        col_pos++;
        if (col_pos >= fw) begin
            col_pos   = 0;
            row_pos++;
            row_start = row_start + fmt_reg[REG_LINE_STRIDE][STRIDE_W-1:0];
            if (row_pos >= fh) begin
                row_pos     = 0;
                row_start   = '0;
                r.frame_end = 1'b1;
            end
        end
        expected_pixels.push_back(r);
    endtask

    // sender: acceptance seen at the rising edge, next transfer set up at the falling edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sent = 1'b1;
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || sent) begin
            if (sent) begin
                predict_packed_pixel(pixel_queue.pop_front());
                sent = 1'b0;
            end
            if (pixel_queue.size() != 0 && !hold_send &&
                !(gaps_on && $urandom_range(99) < 17)) begin
                s_valid <= 1'b1;
                s_red   <= pixel_queue[0].red;
                s_green <= pixel_queue[0].green;
                s_blue  <= pixel_queue[0].blue;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_kick) begin
            stall_kick = 1'b0;
            stall_left <= 80;
            m_ready    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= !(gaps_on && $urandom_range(99) < 17);
        end
    end

    task automatic note_mismatch(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                note_mismatch($sformatf("unexpected transfer, offset %h bytes %h",
                                        m_byte_offset, m_pixel_bytes));
            end else begin
                want = expected_pixels.pop_front();
                if (m_byte_offset !== want.byte_offset)
                    note_mismatch($sformatf("byte_offset expected %h got %h",
                                            want.byte_offset, m_byte_offset));
                if (m_pixel_bytes !== want.pixel_bytes)
                    note_mismatch($sformatf("pixel_bytes expected %h got %h",
                                            want.pixel_bytes, m_pixel_bytes));
                if (m_byte_cnt !== want.byte_cnt)
                    note_mismatch($sformatf("byte_cnt expected %0d got %0d",
                                            want.byte_cnt, m_byte_cnt));
                if (m_frame_end !== want.frame_end)
                    note_mismatch($sformatf("frame_end expected %b got %b",
                                            want.frame_end, m_frame_end));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pixel_queue.size() != 0 || s_valid || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [MASK_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        fmt_reg[idx] = val;
    endtask

    task automatic program_format(input logic [31:0] rm, input logic [31:0] gm,
                                  input logic [31:0] bm, input logic [31:0] bpp,
                                  input logic [31:0] lsb, input logic [31:0] fw,
                                  input logic [31:0] fh, input logic [31:0] stride);
        wait_idle();
        cfg_write(REG_RED_MASK, rm);
        cfg_write(REG_GREEN_MASK, gm);
        cfg_write(REG_BLUE_MASK, bm);
        cfg_write(REG_BPP, bpp & 32'h3F);
        cfg_write(REG_LOW_FIRST, lsb & 32'h1);
        cfg_write(REG_FRAME_WIDTH, fw & 32'h1FFF);
        cfg_write(REG_FRAME_HGT, fh & 32'h1FFF);
        cfg_write(REG_LINE_STRIDE, stride & 32'h7FFF);
        // mask decode lags the write
        repeat (2) @(posedge aclk);
    endtask

    task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        rgb_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        pixel_queue.push_back(px);
    endtask

    function automatic logic [7:0] rand_level();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] rand_mask();
        int unsigned w;
        int unsigned sh;
        logic [63:0] run;
        w   = $urandom_range(1, 32);
        sh  = $urandom_range(0, 32 - w);
        run = ((64'd1 << w) - 64'd1) << sh;
        case ($urandom_range(5))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            4:       return $urandom;
            // lowest run plus stray bits above it
            5:       return run[31:0] | ($urandom & ~((32'h1 << (sh + w)) - 1));
            default: return run[31:0];
        endcase
    endfunction

    function automatic logic [31:0] rand_dim();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return $urandom_range(0, 8191);
            2:       return $urandom_range(7, 40);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    task automatic random_format();
        program_format(rand_mask(), rand_mask(), rand_mask(),
                       ($urandom_range(2) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 32),
                       $urandom_range(1), rand_dim(), rand_dim(),
                       ($urandom_range(3) == 0) ? $urandom_range(0, 32767)
                                                : $urandom_range(0, 64));
    endtask

    task automatic queue_random_pixels(input int unsigned n);
        for (int i = 0; i < n; i++)
            queue_pixel(rand_level(), rand_level(), rand_level());
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset format: 32-bit xRGB, LSB first
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd255, 8'd0, 8'd0);
        queue_pixel(8'd0, 8'd255, 8'd0);
        queue_pixel(8'd0, 8'd0, 8'd255);

        // split red run, empty green, full-width blue, zero stride, frame shrunk mid-row
        program_format(32'h0F0F_0000, 32'h0, 32'hFFFF_FFFF, 24, 0, 2, 2, 0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd128, 8'd7, 8'd1);
        queue_pixel(8'd1, 8'd200, 8'd254);
        queue_pixel(8'd255, 8'd255, 8'd0);
        queue_pixel(8'd0, 8'd0, 8'd255);

        // top-bit mask, zero bpp, zero width, oversize height, widest stride
        program_format(32'h8000_0000, 32'h0F00_0FF0, 32'h0000_0001, 0, 1, 0, 8191, 32767);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd127, 8'd128, 8'd0);
        queue_pixel(8'd128, 8'd1, 8'd1);
        queue_pixel(8'd0, 8'd254, 8'd255);

        // RGB565 with oversize bpp, oversize width, zero height
        program_format(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 63, 0, 8191, 0, 16384);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd8, 8'd4, 8'd8);
        queue_pixel(8'd247, 8'd3, 8'd200);
        queue_pixel(8'd0, 8'd0, 8'd0);

        // one-byte pixels on a single-row frame
        program_format(32'hFF00_0000, 32'h00FF_0000, 32'h0000_FF00, 1, 1, 3, 1, 1);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd10, 8'd20, 8'd30);
        queue_pixel(8'd0, 8'd0, 8'd255);
        queue_pixel(8'd255, 8'd0, 8'd0);

        for (int p = 0; p < 6; p++) begin
            random_format();
            queue_random_pixels(60);
        end

        // no idling on either side
        random_format();
        gaps_on = 1'b0;
        queue_random_pixels(100);
        wait_idle();
        gaps_on = 1'b1;

        // receiver holds off while the sender keeps offering
        random_format();
        queue_random_pixels(90);
        @(posedge aclk);
        stall_kick = 1'b1;

        // sender pauses until everything has drained
        random_format();
        queue_random_pixels(40);
        while (pixel_queue.size() > 20)
            @(posedge aclk);
        hold_send = 1'b1;
        while (s_valid || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        hold_send = 1'b0;

        // close the frame, then a tall narrow frame with the widest stride
        program_format(rand_mask(), rand_mask(), rand_mask(), 32, 1, 1, 1, 1);
        queue_random_pixels(1);
        program_format(rand_mask(), rand_mask(), rand_mask(), $urandom_range(1, 32),
                       $urandom_range(1), 1, 4096, 32767);
        queue_random_pixels(200);

        wait_idle();
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== rgb888_to_masked_pixel_packer.f =====
hw/rtl/rgbmpp_pkg.sv
hw/rtl/rgbmpp_cfg.sv
hw/rtl/rgbmpp_front.sv
hw/rtl/rgbmpp_queue.sv
hw/rtl/rgbmpp_back.sv
hw/rtl/rgb888_to_masked_pixel_packer.sv
dv/tb.sv
